[rtl/core/assert_macros.svh]
// Assertion macros shared by the console core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that an implication holds at every clock edge outside reset.
`define CHECK_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// Check that the consequent holds in the cycle after the antecedent.
`define CHECK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`endif

[rtl/core/tcce_pkg.sv]
// ----------------------------------------------------------------------------
// Console core package
// Shared constants, command codes and the memory control struct.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tcce_pkg;
  localparam int DefCols = 80;
  localparam int DefRows = 25;
  localparam int PosW = 11;
  localparam logic [7:0] BlankAttr = 8'h07;
  localparam logic [7:0] ChStar = 8'h2a;
  localparam logic [7:0] ChNl = 8'h0a;
  localparam logic [7:0] ChCr = 8'h0d;
  localparam logic [7:0] ChSpace = 8'h20;

  localparam logic [3:0] CmdPutAttr = 4'd0;
  localparam logic [3:0] CmdPutDef = 4'd1;
  localparam logic [3:0] CmdBksp = 4'd2;
  localparam logic [3:0] CmdErase = 4'd3;
  localparam logic [3:0] CmdEraseBack = 4'd4;
  localparam logic [3:0] CmdRight = 4'd5;
  localparam logic [3:0] CmdLeft = 4'd6;
  localparam logic [3:0] CmdUp = 4'd7;
  localparam logic [3:0] CmdDown = 4'd8;
  localparam logic [3:0] CmdClear = 4'd9;
  localparam logic [3:0] CmdRead = 4'd10;

  localparam logic [1:0] RegPrintEn = 2'd0;
  localparam logic [1:0] RegMask = 2'd1;
  localparam logic [1:0] RegDefAttr = 2'd2;

  typedef struct packed {
    logic             we;
    logic [PosW-1:0]  waddr;
    logic [15:0]      wdata;
    logic [PosW-1:0]  raddr;
  } mem_ctl_t;
endpackage

[rtl/core/text_console_cursor_engine_core.sv]
// ----------------------------------------------------------------------------
// Console cursor engine core
// Clear and scrolling walk the whole screen, and erase-back walks back over
// space cells; other commands go straight to their result.
// One command at a time: start is taken only while busy is low; no stalls.
// Reset: rst clears the screen with busy high and gives no result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module text_console_cursor_engine_core #(
  parameter int COLS = tcce_pkg::DefCols,
  parameter int ROWS = tcce_pkg::DefRows
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  req_type,
  input  logic [7:0]  char_code,
  input  logic [7:0]  char_attr,
  input  logic [10:0] cell_index,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        done,
  output logic [10:0] cursor_pos,
  output logic [7:0]  cell_char,
  output logic [7:0]  cell_attr
);
  import tcce_pkg::*;
`include "assert_macros.svh"
  logic print_en, mask_en;
  logic [7:0] def_attr;
  mem_ctl_t ctl;
  logic [15:0] rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      print_en <= 1'b1; mask_en <= 1'b0; def_attr <= BlankAttr;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegPrintEn: print_en <= cfg_data[0];
        RegMask: mask_en <= cfg_data[0];
        RegDefAttr: def_attr <= cfg_data;
        default: ;
      endcase
    end
  end

  tcce_ctrl #(.Cols(COLS), .Rows(ROWS)) u_ctrl (
    .clk, .rst, .start, .req_type, .char_code, .char_attr, .cell_index,
    .print_en, .mask_en, .def_attr, .rdata, .ctl, .busy, .done,
    .cursor_pos, .cell_char, .cell_attr
  );

  tcce_mem #(.Cells(COLS * ROWS)) u_mem (.clk, .ctl(ctl), .rdata);

  `CHECK_IMPL(a_done_idle, clk, rst, done, !busy)
  `CHECK_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `CHECK_IMPL(a_cursor_range, clk, rst, done, cursor_pos < 11'(COLS * ROWS))
endmodule

[rtl/core/tcce_mem.sv]
// ----------------------------------------------------------------------------
// Console screen memory
// Single-port-write, single-read synchronous cell store with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tcce_mem #(
  parameter int Cells = 2000
) (
  input  logic              clk,
  input  tcce_pkg::mem_ctl_t ctl,
  output logic [15:0]       rdata
);
  import tcce_pkg::*;
  localparam int AW = $clog2(Cells);
  logic [15:0] mem [Cells];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr[AW-1:0]] <= ctl.wdata;
    end
    rdata <= mem[ctl.raddr[AW-1:0]];
  end
endmodule

[rtl/core/tcce_ctrl.sv]
// ----------------------------------------------------------------------------
// Console command sequencer
// Decodes commands, walks the memory for scroll, clear and erase-back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tcce_ctrl #(
  parameter int Cols = 80,
  parameter int Rows = 25
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [3:0]                req_type,
  input  logic [7:0]                char_code,
  input  logic [7:0]                char_attr,
  input  logic [10:0]               cell_index,
  input  logic                      print_en,
  input  logic                      mask_en,
  input  logic [7:0]                def_attr,
  input  logic [15:0]               rdata,
  output tcce_pkg::mem_ctl_t        ctl,
  output logic                      busy,
  output logic                      done,
  output logic [10:0]               cursor_pos,
  output logic [7:0]                cell_char,
  output logic [7:0]                cell_attr
);
  import tcce_pkg::*;
  localparam int Cells = Cols * Rows;
  localparam logic [PosW-1:0] CellsP = PosW'(Cells);
  localparam logic [PosW-1:0] ColsP = PosW'(Cols);
  localparam logic [PosW-1:0] LastRowP = PosW'(Cells - Cols);
  localparam logic [PosW-1:0] LastCellP = PosW'(Cells - 1);
  localparam logic [PosW-1:0] LastColP = PosW'(Cols - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_SCR_RD, S_SCR_WR, S_SCR_BLANK, S_BACK_RD, S_BACK_CHK,
    S_READ, S_DONE
  } state_t;

  state_t state;
  logic [PosW-1:0] cursor;
  logic [PosW-1:0] col;
  logic [PosW-1:0] ptr;
  logic [PosW-1:0] pcol;
  logic            rd_hit;
  logic            clr_ack;
  mem_ctl_t        ctl_next;
  logic [7:0]      pch;
  logic [PosW:0]   up;

  assign busy = (state != S_IDLE);

  always_comb begin
    ctl_next = '0;
    pch = (mask_en && char_code != ChNl) ? ChStar : char_code;
    up = {1'b0, cursor} + {1'b0, ColsP} - {1'b0, col};
    unique case (state)
      S_IDLE: begin
        if (start) begin
          case (req_type) inside
            CmdPutAttr, CmdPutDef: begin
              if (print_en && pch != ChNl && pch != ChCr) begin
                ctl_next.we = 1'b1;
                ctl_next.waddr = cursor;
                ctl_next.wdata = {(req_type == CmdPutAttr) ? char_attr : def_attr, pch};
              end
            end
            CmdBksp: begin
              if (cursor != '0) begin
                ctl_next.we = 1'b1;
                ctl_next.waddr = cursor - 1'b1;
                ctl_next.wdata = {BlankAttr, 8'h00};
              end
            end
            CmdErase: begin
              ctl_next.we = 1'b1;
              ctl_next.waddr = cursor;
              ctl_next.wdata = {BlankAttr, ChSpace};
            end
            CmdEraseBack: ctl_next.raddr = cursor - 1'b1;
            CmdRead: ctl_next.raddr = cell_index;
            default: ;
          endcase
        end
      end
      S_CLEAR: begin
        ctl_next.we = 1'b1;
        ctl_next.waddr = ptr;
        ctl_next.wdata = {BlankAttr, 8'h00};
      end
      S_SCR_RD: begin
        ctl_next.raddr = ptr + ColsP;
      end
      S_SCR_WR: begin
        ctl_next.we = 1'b1;
        ctl_next.waddr = ptr;
        ctl_next.wdata = rdata;
      end
      S_SCR_BLANK: begin
        ctl_next.we = 1'b1;
        ctl_next.waddr = ptr;
        ctl_next.wdata = {BlankAttr, 8'h00};
      end
      S_BACK_RD: begin
        ctl_next.raddr = ptr;
      end
      S_BACK_CHK: begin
        if (rdata[7:0] == ChSpace) begin
          ctl_next.we = 1'b1;
          ctl_next.waddr = ptr;
          ctl_next.wdata = {BlankAttr, ChSpace};
        end
      end
      default: ;
    endcase
  end

  assign ctl = ctl_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cursor <= '0;
      col <= '0;
      ptr <= '0;
      pcol <= '0;
      rd_hit <= 1'b0;
      clr_ack <= 1'b0;
      done <= 1'b0;
      cursor_pos <= '0;
      cell_char <= '0;
      cell_attr <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_DONE;
            case (req_type) inside
              CmdPutAttr, CmdPutDef: begin
                if (print_en) begin
                  if (pch == ChNl) begin
                    col <= '0;
                    if (up >= {1'b0, CellsP}) begin
                      cursor <= up[PosW-1:0] - ColsP;
                      ptr <= '0;
                      state <= S_SCR_RD;
                    end else begin
                      cursor <= up[PosW-1:0];
                    end
                  end else if (pch == ChCr) begin
                    cursor <= cursor - col;
                    col <= '0;
                  end else if (cursor == LastCellP) begin
                    cursor <= LastRowP;
                    col <= '0;
                    ptr <= '0;
                    state <= S_SCR_RD;
                  end else begin
                    cursor <= cursor + 1'b1;
                    col <= (col == LastColP) ? '0 : col + 1'b1;
                  end
                end
              end
              CmdBksp: begin
                if (cursor != '0) begin
                  cursor <= cursor - 1'b1;
                  col <= (col == '0) ? LastColP : col - 1'b1;
                end
              end
              CmdEraseBack: begin
                if (cursor != '0) begin
                  ptr <= cursor - 1'b1;
                  pcol <= (col == '0) ? LastColP : col - 1'b1;
                  state <= S_BACK_CHK;
                end
              end
              CmdRight: begin
                if (cursor == LastCellP) begin
                  cursor <= LastRowP;
                  col <= '0;
                  ptr <= '0;
                  state <= S_SCR_RD;
                end else begin
                  cursor <= cursor + 1'b1;
                  col <= (col == LastColP) ? '0 : col + 1'b1;
                end
              end
              CmdLeft: begin
                if (cursor != '0) begin
                  cursor <= cursor - 1'b1;
                  col <= (col == '0) ? LastColP : col - 1'b1;
                end
              end
              CmdUp: if (cursor >= ColsP) cursor <= cursor - ColsP;
              CmdDown: if (cursor < LastRowP) cursor <= cursor + ColsP;
              CmdClear: begin
                cursor <= '0;
                col <= '0;
                ptr <= '0;
                clr_ack <= 1'b1;
                state <= S_CLEAR;
              end
              CmdRead: begin
                rd_hit <= (cell_index < CellsP);
                state <= S_READ;
              end
              default: ;
            endcase
          end
        end
        S_CLEAR: begin
          ptr <= ptr + 1'b1;
          if (ptr == LastCellP) begin
            state <= clr_ack ? S_DONE : S_IDLE;
            clr_ack <= 1'b0;
          end
        end
        S_SCR_RD: begin
          state <= S_SCR_WR;
        end
        S_SCR_WR: begin
          ptr <= ptr + 1'b1;
          state <= (ptr == LastRowP - 1'b1) ? S_SCR_BLANK : S_SCR_RD;
        end
        S_SCR_BLANK: begin
          ptr <= ptr + 1'b1;
          if (ptr == LastCellP) state <= S_DONE;
        end
        S_BACK_RD: begin
          state <= S_BACK_CHK;
        end
        S_BACK_CHK: begin
          if (rdata[7:0] != ChSpace) begin
            cursor <= ptr + 1'b1;
            col <= (pcol == LastColP) ? '0 : pcol + 1'b1;
            state <= S_DONE;
          end else if (ptr == '0) begin
            cursor <= '0;
            col <= '0;
            state <= S_DONE;
          end else begin
            ptr <= ptr - 1'b1;
            pcol <= (pcol == '0) ? LastColP : pcol - 1'b1;
            state <= S_BACK_RD;
          end
        end
        S_READ: begin
          done <= 1'b1;
          cursor_pos <= cursor;
          cell_char <= rd_hit ? rdata[7:0] : 8'h00;
          cell_attr <= rd_hit ? rdata[15:8] : 8'h00;
          state <= S_IDLE;
        end
        S_DONE: begin
          done <= 1'b1;
          cursor_pos <= cursor;
          cell_char <= '0;
          cell_attr <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[sim/text_console_cursor_engine_core_tb.sv]
// ----------------------------------------------------------------------------
// Console cursor engine testbench
// Drives command transfers into the console core, predicts the screen, the
// cursor and each read, and checks every result against that prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module text_console_cursor_engine_core_tb;
  import tcce_pkg::*;

  localparam int Cols = DefCols;
  localparam int Rows = DefRows;
  localparam int Cells = Cols * Rows;
  localparam int WatchLimit = 60000;

  typedef struct packed {
    logic [10:0] pos;
    logic [7:0]  ch;
    logic [7:0]  attr;
  } console_out_t;

  class console_scoreboard;
    logic [7:0] scr_ch [Cells];
    logic [7:0] scr_attr [Cells];
    int unsigned cur;
    bit print_en;
    bit mask_on;
    logic [7:0] def_attr;
    console_out_t expected_q[$];
    int errors;
    int commands;
    int results;
    int scrolls;
    int reads;

    function new();
      blank_screen();
      cur = 0;
      print_en = 1;
      mask_on = 0;
      def_attr = BlankAttr;
      errors = 0;
      commands = 0;
      results = 0;
      scrolls = 0;
      reads = 0;
    endfunction

    function void blank_screen();
      for (int i = 0; i < Cells; i++) begin
        scr_ch[i] = 8'h00;
        scr_attr[i] = BlankAttr;
      end
    endfunction

    function void wrap_cursor();
      if (cur >= Cells) begin
        for (int i = 0; i < Cells - Cols; i++) begin
          scr_ch[i] = scr_ch[i + Cols];
          scr_attr[i] = scr_attr[i + Cols];
        end
        for (int i = Cells - Cols; i < Cells; i++) begin
          scr_ch[i] = 8'h00;
          scr_attr[i] = BlankAttr;
        end
        cur = cur - Cols;
        scrolls++;
      end
    endfunction

    function void put_char(logic [7:0] c, logic [7:0] a);
      logic [7:0] pc;
      pc = c;
      if (!print_en) return;
      if (mask_on && pc != ChNl) pc = ChStar;
      if (pc == ChNl) begin
        cur = cur + Cols - (cur % Cols);
      end else if (pc == ChCr) begin
        cur = cur - (cur % Cols);
      end else begin
        scr_ch[cur] = pc;
        scr_attr[cur] = a;
        cur++;
      end
      wrap_cursor();
    endfunction

    function void erase_spaces_back();
      int p;
      bit walking;
      if (cur == 0) return;
      p = cur - 1;
      walking = 1;
      while (walking) begin
        if (scr_ch[p] != ChSpace) begin
          cur = p + 1;
          walking = 0;
        end else begin
          scr_attr[p] = BlankAttr;
          if (p == 0) begin
            cur = 0;
            walking = 0;
          end else begin
            p--;
          end
        end
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] data);
      if (idx == RegPrintEn) print_en = data[0];
      else if (idx == RegMask) mask_on = data[0];
      else if (idx == RegDefAttr) def_attr = data;
    endfunction

    function void note_command(logic [3:0] req, logic [7:0] c, logic [7:0] a,
                               logic [10:0] idx);
      console_out_t r;
      r = '0;
      commands++;
      case (req)
        CmdPutAttr: put_char(c, a);
        CmdPutDef: put_char(c, def_attr);
        CmdBksp: begin
          if (cur > 0) begin
            cur--;
            scr_ch[cur] = 8'h00;
            scr_attr[cur] = BlankAttr;
          end
        end
        CmdErase: begin
          scr_ch[cur] = ChSpace;
          scr_attr[cur] = BlankAttr;
        end
        CmdEraseBack: erase_spaces_back();
        CmdRight: begin
          cur++;
          wrap_cursor();
        end
        CmdLeft: if (cur > 0) cur--;
        CmdUp: if (cur >= Cols) cur = cur - Cols;
        CmdDown: if (cur < Cells - Cols) cur = cur + Cols;
        CmdClear: begin
          blank_screen();
          cur = 0;
        end
        CmdRead: begin
          reads++;
          if (idx < Cells) begin
            r.ch = scr_ch[idx];
            r.attr = scr_attr[idx];
          end
        end
        default: ;
      endcase
      r.pos = cur[10:0];
      expected_q.push_back(r);
    endfunction

    task report(string what, logic [10:0] got, logic [10:0] want);
      $display("%0t mismatch in %s: got %0d, expected %0d", $time, what, got, want);
      errors++;
    endtask

    task check_result(logic [10:0] pos, logic [7:0] c, logic [7:0] a);
      console_out_t e;
      if (expected_q.size() == 0) begin
        report("unexpected result cursor_pos", pos, 0);
        return;
      end
      e = expected_q.pop_front();
      results++;
      if (pos !== e.pos) report("cursor_pos", pos, e.pos);
      if (c !== e.ch) report("cell_char", {3'b0, c}, {3'b0, e.ch});
      if (a !== e.attr) report("cell_attr", {3'b0, a}, {3'b0, e.attr});
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [3:0]  req_type;
  logic [7:0]  char_code;
  logic [7:0]  char_attr;
  logic [10:0] cell_index;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        done;
  logic [10:0] cursor_pos;
  logic [7:0]  cell_char;
  logic [7:0]  cell_attr;

  console_scoreboard sb;
  bit idle_on;
  int quiet_cycles;

  text_console_cursor_engine_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .char_code(char_code), .char_attr(char_attr),
    .cell_index(cell_index), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .cursor_pos(cursor_pos),
    .cell_char(cell_char), .cell_attr(cell_attr)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(cursor_pos, cell_char, cell_attr);
    if ((start && !busy && !rst) || done) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles > WatchLimit) begin
        $display("timeout: no transfer for %0d cycles", WatchLimit);
        $display("[text_console_cursor_engine_core] ERROR");
        $finish;
      end
    end
  end

  task send_command(logic [3:0] req, logic [7:0] c, logic [7:0] a, logic [10:0] idx);
    start <= 1'b1;
    req_type <= req;
    char_code <= c;
    char_attr <= a;
    cell_index <= idx;
    do @(posedge clk); while (busy);
    sb.note_command(req, c, a, idx);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task write_cfg(logic [1:0] idx, logic [7:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task random_command();
    int r;
    logic [3:0] req;
    logic [7:0] c;
    logic [10:0] idx;
    r = $urandom_range(0, 99);
    c = 8'($urandom_range(0, 255));
    idx = 11'($urandom_range(0, 2047));
    if (r < 45) begin
      req = $urandom_range(0, 1) ? CmdPutAttr : CmdPutDef;
      case ($urandom_range(0, 9))
        0, 1: c = ChNl;
        2: c = ChCr;
        3, 4, 5: c = ChSpace;
        default: ;
      endcase
    end else if (r < 52) req = CmdBksp;
    else if (r < 57) req = CmdErase;
    else if (r < 64) req = CmdEraseBack;
    else if (r < 70) req = CmdRight;
    else if (r < 75) req = CmdLeft;
    else if (r < 80) req = CmdUp;
    else if (r < 85) req = CmdDown;
    else if (r < 87) req = CmdClear;
    else if (r < 97) begin
      req = CmdRead;
      if ($urandom_range(0, 9) != 0) idx = 11'($urandom_range(0, Cells - 1));
    end else req = 4'($urandom_range(11, 15));
    send_command(req, c, 8'($urandom_range(0, 255)), idx);
  endtask

  initial begin
    sb = new();
    idle_on = 1;
    quiet_cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    req_type = '0;
    char_code = '0;
    char_attr = '0;
    cell_index = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_command(CmdBksp, 8'h00, 8'h00, 11'd0);
    send_command(CmdLeft, 8'hff, 8'hff, 11'd2047);
    send_command(CmdUp, 8'h00, 8'h00, 11'd0);
    send_command(CmdPutAttr, 8'hff, 8'hff, 11'd0);
    send_command(CmdPutAttr, 8'h00, 8'h00, 11'd0);
    send_command(CmdPutDef, ChSpace, 8'h55, 11'd0);
    send_command(CmdPutDef, ChSpace, 8'haa, 11'd0);
    send_command(CmdEraseBack, 8'h00, 8'h00, 11'd0);
    send_command(CmdErase, 8'h00, 8'h00, 11'd0);
    send_command(CmdRead, 8'h00, 8'h00, 11'd0);
    send_command(CmdRead, 8'h00, 8'h00, 11'd1999);
    send_command(CmdRead, 8'h00, 8'h00, 11'd2000);
    send_command(CmdRead, 8'h00, 8'h00, 11'd2047);
    send_command(CmdPutAttr, ChCr, 8'h00, 11'd0);
    send_command(CmdPutAttr, ChNl, 8'h00, 11'd0);
    send_command(CmdRight, 8'h00, 8'h00, 11'd0);
    for (int i = 0; i < Rows; i++) send_command(CmdDown, 8'h00, 8'h00, 11'd0);
    send_command(4'd11, 8'h00, 8'h00, 11'd0);
    send_command(4'd15, 8'hff, 8'hff, 11'd2047);
    send_command(CmdClear, 8'h00, 8'h00, 11'd0);
    send_command(CmdPutDef, ChSpace, 8'h00, 11'd0);
    send_command(CmdPutDef, ChSpace, 8'h00, 11'd0);
    send_command(CmdPutDef, ChSpace, 8'h00, 11'd0);
    send_command(CmdEraseBack, 8'h00, 8'h00, 11'd0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_cfg(RegDefAttr, 8'hff);
        end
        1: begin
          write_cfg(RegMask, 8'h01);
          write_cfg(RegDefAttr, 8'h00);
        end
        2: begin
          write_cfg(RegPrintEn, 8'h00);
          write_cfg(RegMask, 8'h00);
          write_cfg(2'd3, 8'hff);
        end
        3: begin
          write_cfg(RegPrintEn, 8'hff);
          write_cfg(RegDefAttr, 8'($urandom_range(0, 255)));
        end
        default: begin
          write_cfg(RegDefAttr, 8'h07);
          idle_on = 0;
        end
      endcase
      for (int i = 0; i < 125; i++) random_command();
      drain();
    end

    $display("Covered %0d commands and %0d results, with %0d reads and %0d scrolls,",
             sb.commands, sb.results, sb.reads, sb.scrolls);
    $display("over five register settings including mask mode and printing disabled.");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[text_console_cursor_engine_core] OK");
    end else begin
      $display("[text_console_cursor_engine_core] ERROR");
    end
    $finish;
  end
endmodule
